// File: sv/palette_fade_engine_macros.svh
// Assertion macros for the palette fade engine.
`ifndef PALETTE_FADE_ENGINE_MACROS_SVH
`define PALETTE_FADE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check on an explicit clock and active-low reset.
`define PFE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check on the block clock and reset.
`define PFE_ASSERT(label, prop, msg) \
  `PFE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define PFE_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define PFE_ASSERT(label, prop, msg)
`endif

`endif

// File: sv/pfe_pkg.sv
// Types and constants of the palette fade engine.
package pfe_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FILL,
    S_TICK,
    S_FINISH
  } pfe_state_e;

  typedef enum logic [2:0] {
    MODE_WR_TARGET  = 3'd0,
    MODE_WR_CURRENT = 3'd1,
    MODE_RD_CURRENT = 3'd2,
    MODE_START      = 3'd3,
    MODE_TICK       = 3'd4
  } pfe_mode_e;

  typedef enum logic [1:0] {
    KIND_FADE_IN   = 2'd0,
    KIND_FADE_OUT  = 2'd1,
    KIND_FLASH_IN  = 2'd2,
    KIND_FLASH_OUT = 2'd3
  } pfe_kind_e;

  typedef enum logic [1:0] {
    CFG_FIRST_ENTRY = 2'd0,
    CFG_LAST_OFFSET = 2'd1,
    CFG_SKIP_BANK   = 2'd2
  } pfe_cfg_e;

  localparam logic [7:0] STEP       = 8'd32;
  localparam logic [7:0] WHITE      = 8'd224;
  localparam logic [5:0] FIRST_RST  = 6'd0;
  localparam logic [5:0] LAST_RST   = 6'd63;

endpackage

// File: sv/palette_fade_engine.sv
// Palette fade engine: two-bank current/target RGB palette with frame-stepped fades.
//
// The block holds a current and a target palette of two banks of ENTRIES RGB
// entries each, in two single-write memories with registered reads. One
// transaction on the input channel carries one item and gives exactly one
// result transaction: write target, write current, read current, start fade
// or frame tick. Items are worked one at a time; in_stall_o is high from the
// accept until the item's result sits in the output register, so the next item
// is taken while a result still waits. A fade-in or flash-in start first fills
// bank 0 (the fade-in range, or all ENTRIES entries); an active tick steps
// ENTRIES entries or the fade-in range, in one bank or in both. A tick steps
// one entry per cycle through a single step unit: the read of one entry
// overlaps the write-back of the one before, so the memory ports set the rate.
// Each step moves one channel by 32, modulo 256: toward target blue, green,
// red for the in-modes, red, green, blue for the out-modes. The fade ends on
// the tick that takes the frame count past LAST_FRAME. After reset a clearing
// pass over all 2*ENTRIES entries zeroes both palettes; no item is taken
// meanwhile, while configuration writes are always taken.
`include "palette_fade_engine_macros.svh"

module palette_fade_engine #(
  parameter int ENTRIES    = 64,
  parameter int LAST_FRAME = 21
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic       bank_i,
  input  logic [5:0] entry_index_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [1:0] fade_kind_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic       fade_done_o,
  output logic       fade_busy_o,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i
);

  localparam int DEPTH = 2 * ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(ENTRIES);
  // loop counter must hold the clipped range end and first_entry + last_offset
  localparam int W     = ($clog2(ENTRIES) + 1 > 7) ? $clog2(ENTRIES) + 1 : 7;

  localparam logic [AW-1:0] ENT_A    = AW'(ENTRIES);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [W-1:0]  LAST_ENT = W'(ENTRIES - 1);
  localparam logic [5:0]    LAST_FR  = 6'(LAST_FRAME);

  // ------------------------------------------------------------------
  // step unit: one channel of one entry per call
  // ------------------------------------------------------------------
  function automatic logic [23:0] step_toward(input logic [23:0] cur,
                                              input logic [23:0] tgt,
                                              input logic        up);
    logic [23:0] r;
    logic        hit;
    r   = cur;
    hit = 1'b0;
    if (cur != tgt) begin
      for (int k = 0; k < 3; k++) begin
        if (!hit) begin
          if (up ? (tgt[8*k +: 8] > cur[8*k +: 8]) : (tgt[8*k +: 8] < cur[8*k +: 8])) begin
            r[8*k +: 8] = up ? cur[8*k +: 8] + pfe_pkg::STEP
                             : cur[8*k +: 8] - pfe_pkg::STEP;
            hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [23:0] step_out(input logic [23:0] cur,
                                           input logic        white);
    logic [23:0] r;
    logic        hit;
    logic [7:0]  stop;
    r    = cur;
    hit  = 1'b0;
    stop = white ? pfe_pkg::WHITE : 8'd0;
    for (int k = 2; k >= 0; k--) begin
      if (!hit && (cur[8*k +: 8] != stop)) begin
        r[8*k +: 8] = white ? cur[8*k +: 8] + pfe_pkg::STEP
                            : cur[8*k +: 8] - pfe_pkg::STEP;
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  pfe_pkg::pfe_state_e state_q, state_d;

  // latched item
  logic [2:0]  mode_q;
  logic        ibank_q;
  logic [5:0]  idx_q;
  logic [23:0] col_q;
  logic [1:0]  ikind_q;

  // configuration
  logic [5:0] first_q, first_d;
  logic [5:0] last_q, last_d;
  logic       skip_q, skip_d;

  // fade state
  logic [1:0] akind_q, akind_d;
  logic       active_q, active_d;
  logic [4:0] frame_q, frame_d;

  // sweep sequencer
  logic [W-1:0]  cnt_q, cnt_d;
  logic          sbank_q, sbank_d;
  logic          issue_q, issue_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] waddr_q, waddr_d;
  logic [AW-1:0] clr_q, clr_d;

  // pending result and output register
  logic [23:0] res_col_q, res_col_d;
  logic        res_done_q, res_done_d;
  logic        out_valid_q, out_valid_d;
  logic [23:0] out_col_q;
  logic        out_done_q, out_busy_q;
  logic        out_load;

  // memories
  logic [23:0]   cur_mem [DEPTH];
  logic [23:0]   tgt_mem [DEPTH];
  logic [23:0]   cur_rd_q, tgt_rd_q;
  logic          cur_we, tgt_we;
  logic [AW-1:0] cur_wa, tgt_wa, rd_addr;
  logic [23:0]   cur_wd, tgt_wd;

  // ------------------------------------------------------------------
  // shared decode
  // ------------------------------------------------------------------
  logic          in_accept;
  logic          item_ok;
  logic [AW-1:0] item_addr;
  logic [1:0]    sel_kind;
  logic          is_fi, two_banks, empty_r;
  logic [W-1:0]  lo_fi, sum_fi, lo_r, hi_r;
  logic [AW-1:0] sweep_addr;
  logic          at_end, tick_last, tick_end;
  logic [5:0]    frame_nx;
  logic [23:0]   step_res;

  assign in_accept = in_valid_i && !in_stall_o;
  assign item_ok   = (32'(idx_q) < ENTRIES);
  assign item_addr = AW'(idx_q) + (ibank_q ? ENT_A : '0);

  // range follows the item kind while starting, the running kind otherwise
  assign sel_kind  = ((state_q == pfe_pkg::S_EXEC) && (mode_q == pfe_pkg::MODE_START))
                     ? ikind_q : akind_q;
  assign is_fi     = (sel_kind == pfe_pkg::KIND_FADE_IN);
  assign two_banks = !(((sel_kind == pfe_pkg::KIND_FADE_IN) ||
                        (sel_kind == pfe_pkg::KIND_FLASH_IN)) && skip_q);
  assign lo_fi     = W'(first_q);
  assign sum_fi    = W'(first_q) + W'(last_q);
  assign lo_r      = is_fi ? lo_fi : '0;
  assign hi_r      = is_fi ? ((sum_fi > LAST_ENT) ? LAST_ENT : sum_fi) : LAST_ENT;
  assign empty_r   = is_fi && (lo_fi > LAST_ENT);

  assign sweep_addr = AW'(cnt_q[EW-1:0]) + (sbank_q ? ENT_A : '0);
  assign at_end     = (cnt_q == hi_r);
  assign tick_last  = at_end && !(!sbank_q && two_banks);
  assign tick_end   = !issue_q && !pend_q;
  assign frame_nx   = {1'b0, frame_q} + 6'd1;

  always_comb begin
    unique case (pfe_pkg::pfe_kind_e'(akind_q))
      pfe_pkg::KIND_FADE_IN:   step_res = step_toward(cur_rd_q, tgt_rd_q, 1'b1);
      pfe_pkg::KIND_FADE_OUT:  step_res = step_out(cur_rd_q, 1'b0);
      pfe_pkg::KIND_FLASH_IN:  step_res = step_toward(cur_rd_q, tgt_rd_q, 1'b0);
      pfe_pkg::KIND_FLASH_OUT: step_res = step_out(cur_rd_q, 1'b1);
      default:                 step_res = cur_rd_q;
    endcase
  end

  assign out_load = (state_q == pfe_pkg::S_FINISH) && (!out_valid_q || !out_stall_i);

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfe_pkg::S_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = pfe_pkg::S_IDLE;
      end
      pfe_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pfe_pkg::S_EXEC;
      end
      pfe_pkg::S_EXEC: begin
        unique case (pfe_pkg::pfe_mode_e'(mode_q))
          pfe_pkg::MODE_RD_CURRENT: state_d = pfe_pkg::S_READ;
          pfe_pkg::MODE_START: begin
            if ((ikind_q == pfe_pkg::KIND_FADE_IN && !empty_r) ||
                (ikind_q == pfe_pkg::KIND_FLASH_IN)) begin
              state_d = pfe_pkg::S_FILL;
            end else begin
              state_d = pfe_pkg::S_FINISH;
            end
          end
          pfe_pkg::MODE_TICK: state_d = active_q ? pfe_pkg::S_TICK : pfe_pkg::S_FINISH;
          default:            state_d = pfe_pkg::S_FINISH;
        endcase
      end
      pfe_pkg::S_READ: state_d = pfe_pkg::S_FINISH;
      pfe_pkg::S_FILL: begin
        if (at_end) state_d = pfe_pkg::S_FINISH;
      end
      pfe_pkg::S_TICK: begin
        if (tick_end) state_d = pfe_pkg::S_FINISH;
      end
      pfe_pkg::S_FINISH: begin
        if (out_load) state_d = pfe_pkg::S_IDLE;
      end
      default: state_d = pfe_pkg::S_CLEAR;
    endcase
  end

  // ------------------------------------------------------------------
  // datapath and memory control
  // ------------------------------------------------------------------
  always_comb begin
    akind_d    = akind_q;
    active_d   = active_q;
    frame_d    = frame_q;
    cnt_d      = cnt_q;
    sbank_d    = sbank_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    waddr_d    = waddr_q;
    clr_d      = clr_q;
    res_col_d  = res_col_q;
    res_done_d = res_done_q;
    cur_we     = 1'b0;
    cur_wa     = item_addr;
    cur_wd     = col_q;
    tgt_we     = 1'b0;
    tgt_wa     = item_addr;
    tgt_wd     = col_q;
    rd_addr    = item_addr;

    unique case (state_q)
      pfe_pkg::S_CLEAR: begin
        cur_we = 1'b1;
        cur_wa = clr_q;
        cur_wd = '0;
        tgt_we = 1'b1;
        tgt_wa = clr_q;
        tgt_wd = '0;
        clr_d  = clr_q + 1'b1;
      end
      pfe_pkg::S_EXEC: begin
        res_col_d  = '0;
        res_done_d = 1'b0;
        unique case (pfe_pkg::pfe_mode_e'(mode_q))
          pfe_pkg::MODE_WR_TARGET:  tgt_we = item_ok;
          pfe_pkg::MODE_WR_CURRENT: cur_we = item_ok;
          pfe_pkg::MODE_RD_CURRENT: rd_addr = item_addr;
          pfe_pkg::MODE_START: begin
            akind_d  = ikind_q;
            active_d = 1'b1;
            frame_d  = '0;
            cnt_d    = lo_r;
            sbank_d  = 1'b0;
          end
          pfe_pkg::MODE_TICK: begin
            if (!active_q) begin
              res_done_d = 1'b1;
            end else begin
              if (frame_nx > LAST_FR) begin
                frame_d    = '0;
                active_d   = 1'b0;
                res_done_d = 1'b1;
              end else begin
                frame_d = frame_nx[4:0];
              end
              cnt_d   = lo_r;
              sbank_d = 1'b0;
              issue_d = !empty_r;
            end
          end
          default: ;
        endcase
      end
      pfe_pkg::S_READ: begin
        res_col_d = item_ok ? cur_rd_q : '0;
      end
      pfe_pkg::S_FILL: begin
        // bank 0 only: black for fade-in, white for flash-in
        cur_we = 1'b1;
        cur_wa = sweep_addr;
        cur_wd = is_fi ? 24'd0 : {pfe_pkg::WHITE, pfe_pkg::WHITE, pfe_pkg::WHITE};
        cnt_d  = cnt_q + 1'b1;
      end
      pfe_pkg::S_TICK: begin
        // read entry n while entry n-1 is written back
        rd_addr = sweep_addr;
        if (issue_q) begin
          pend_d  = 1'b1;
          waddr_d = sweep_addr;
          if (tick_last) begin
            issue_d = 1'b0;
          end else if (at_end) begin
            sbank_d = 1'b1;
            cnt_d   = lo_r;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (pend_q) begin
          cur_we = 1'b1;
          cur_wa = waddr_q;
          cur_wd = step_res;
        end
      end
      default: ;
    endcase
  end

  // configuration decode
  always_comb begin
    first_d = first_q;
    last_d  = last_q;
    skip_d  = skip_q;
    if (cfg_valid_i) begin
      unique case (pfe_pkg::pfe_cfg_e'(cfg_index_i))
        pfe_pkg::CFG_FIRST_ENTRY: first_d = cfg_data_i;
        pfe_pkg::CFG_LAST_OFFSET: last_d  = cfg_data_i;
        pfe_pkg::CFG_SKIP_BANK:   skip_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) out_valid_d = 1'b1;
  end

  // ------------------------------------------------------------------
  // control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfe_pkg::S_CLEAR;
      first_q     <= pfe_pkg::FIRST_RST;
      last_q      <= pfe_pkg::LAST_RST;
      skip_q      <= 1'b0;
      akind_q     <= pfe_pkg::KIND_FADE_IN;
      active_q    <= 1'b0;
      frame_q     <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      skip_q      <= skip_d;
      akind_q     <= akind_d;
      active_q    <= active_d;
      frame_q     <= frame_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q  <= mode_i;
      ibank_q <= bank_i;
      idx_q   <= entry_index_i;
      col_q   <= {red_in_i, green_in_i, blue_in_i};
      ikind_q <= fade_kind_i;
    end
    cnt_q      <= cnt_d;
    sbank_q    <= sbank_d;
    waddr_q    <= waddr_d;
    res_col_q  <= res_col_d;
    res_done_q <= res_done_d;
    if (out_load) begin
      out_col_q  <= res_col_q;
      out_done_q <= res_done_q;
      out_busy_q <= active_q;
    end
  end

  // palette memories
  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    cur_rd_q <= cur_mem[rd_addr];
    tgt_rd_q <= tgt_mem[rd_addr];
  end

  // ------------------------------------------------------------------
  // ports
  // ------------------------------------------------------------------
  assign in_stall_o  = (state_q != pfe_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_col_q[23:16];
  assign green_out_o = out_col_q[15:8];
  assign blue_out_o  = out_col_q[7:0];
  assign fade_done_o = out_done_q;
  assign fade_busy_o = out_busy_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `PFE_ASSERT(a_accept_blocks, in_accept |=> in_stall_o, "item taken while busy")
  `PFE_ASSERT(a_done_not_busy, (out_valid_o && fade_done_o) |-> !fade_busy_o, "done with busy")
  `PFE_ASSERT(a_frame_range, frame_q <= 5'(LAST_FRAME), "frame count past last frame")
  `PFE_ASSERT(a_pend_in_tick, pend_q |-> (state_q == pfe_pkg::S_TICK), "write-back outside tick")

endmodule

// File: sim/tb_palette_fade_engine.sv
// Self-checking testbench of the palette fade engine: directed and random items against a predictor.
module tb_palette_fade_engine;

  localparam int ENTRIES      = 64;
  localparam int LAST_FRAME   = 21;
  // Stimulus size: random items after the directed part, and how many of
  // them at the tail run with both sides streaming (no gaps, no stalls).
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_ITEMS  = 120;
  // An active tick steps up to 2*ENTRIES entries; wait that out at the end.
  localparam int TAIL_CYCLES  = 2 * ENTRIES + 32;
  // The run is failed once the cycle count passes this limit.
  localparam int CYCLE_LIMIT  = 1000000;

  // Mode codes 5..7 carry no operation; the block must still answer them.
  localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
  // Index 3 on the register channel addresses nothing.
  localparam logic [1:0] CFG_UNUSED        = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       done;
    logic       busy;
  } pal_result_t;

  // Block ports. Every block input is at a known value from time zero.
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [2:0] mode_i        = '0;
  logic       bank_i        = 1'b0;
  logic [5:0] entry_index_i = '0;
  logic [7:0] red_in_i      = '0;
  logic [7:0] green_in_i    = '0;
  logic [7:0] blue_in_i     = '0;
  logic [1:0] fade_kind_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       fade_done_o;
  logic       fade_busy_o;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i   = '0;
  logic [5:0] cfg_data_i    = '0;

  // Shadow copy of the block state, kept in step with every accepted
  // transaction on the item and register channels.
  logic [23:0]        cur_pal [2*ENTRIES];
  logic [23:0]        tgt_pal [2*ENTRIES];
  pfe_pkg::pfe_kind_e fade_kind_q;
  logic               fade_on;
  logic [4:0]         frame_cnt;
  logic [5:0]         cfg_first;
  logic [5:0]         cfg_last;
  logic               cfg_skip;

  pal_result_t pending_results[$];
  int          item_count     = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  bit          quiet          = 1'b0;

  always #2 clk_i = ~clk_i;

  palette_fade_engine #(
    .ENTRIES   (ENTRIES),
    .LAST_FRAME(LAST_FRAME)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .bank_i       (bank_i),
    .entry_index_i(entry_index_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .fade_kind_i  (fade_kind_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .fade_done_o  (fade_done_o),
    .fade_busy_o  (fade_busy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Fade-in works on first..first+offset, clipped at the last entry.
  function automatic void fadein_span(output int lo, output int hi);
    lo = cfg_first;
    hi = cfg_first + cfg_last;
    if (hi > ENTRIES - 1) hi = ENTRIES - 1;
  endfunction

  // In-modes: move the first channel (blue, green, red) that still lags
  // the target; up means fade-in, otherwise flash-in.
  function automatic logic [23:0] step_toward(logic [23:0] cur, logic [23:0] tgt, bit up);
    logic [7:0] c;
    logic [7:0] t;
    if (cur == tgt) return cur;
    for (int k = 0; k < 3; k++) begin
      c = cur[8*k +: 8];
      t = tgt[8*k +: 8];
      if (up ? (t > c) : (t < c)) begin
        cur[8*k +: 8] = up ? c + pfe_pkg::STEP : c - pfe_pkg::STEP;
        return cur;
      end
    end
    return cur;
  endfunction

  // Out-modes: red first, then green, then blue; white means flash-out,
  // which climbs to 224, otherwise fade-out, which drops to zero.
  function automatic logic [23:0] step_out(logic [23:0] cur, bit white);
    logic [7:0] c;
    for (int k = 2; k >= 0; k--) begin
      c = cur[8*k +: 8];
      if (white ? (c != pfe_pkg::WHITE) : (c != 8'd0)) begin
        cur[8*k +: 8] = white ? c + pfe_pkg::STEP : c - pfe_pkg::STEP;
        return cur;
      end
    end
    return cur;
  endfunction

  function automatic pal_result_t predict_palette_item(
      logic [2:0] mode, logic bank, logic [5:0] idx,
      logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [1:0] kind);
    pal_result_t res;
    int          addr;
    int          lo;
    int          hi;
    int          banks;
    int          a;
    res  = '0;
    addr = bank * ENTRIES + idx;
    case (mode)
      pfe_pkg::MODE_WR_TARGET:  tgt_pal[addr] = {r, g, b};
      pfe_pkg::MODE_WR_CURRENT: cur_pal[addr] = {r, g, b};
      pfe_pkg::MODE_RD_CURRENT: {res.red, res.green, res.blue} = cur_pal[addr];
      pfe_pkg::MODE_START: begin
        // Only bank 0 gets the starting colour; a start also restarts.
        if (kind == pfe_pkg::KIND_FADE_IN) begin
          fadein_span(lo, hi);
          for (int i = lo; i <= hi; i++) cur_pal[i] = '0;
        end else if (kind == pfe_pkg::KIND_FLASH_IN) begin
          for (int i = 0; i < ENTRIES; i++)
            cur_pal[i] = {pfe_pkg::WHITE, pfe_pkg::WHITE, pfe_pkg::WHITE};
        end
        fade_kind_q = pfe_pkg::pfe_kind_e'(kind);
        fade_on     = 1'b1;
        frame_cnt   = '0;
      end
      pfe_pkg::MODE_TICK: begin
        if (!fade_on) begin
          res.done = 1'b1;
        end else begin
          lo    = 0;
          hi    = ENTRIES - 1;
          banks = 2;
          if (fade_kind_q == pfe_pkg::KIND_FADE_IN) fadein_span(lo, hi);
          if ((fade_kind_q == pfe_pkg::KIND_FADE_IN ||
               fade_kind_q == pfe_pkg::KIND_FLASH_IN) && cfg_skip)
            banks = 1;
          for (int bk = 0; bk < banks; bk++) begin
            for (int i = lo; i <= hi; i++) begin
              a = bk * ENTRIES + i;
              case (fade_kind_q)
                pfe_pkg::KIND_FADE_IN:
                  cur_pal[a] = step_toward(cur_pal[a], tgt_pal[a], 1'b1);
                pfe_pkg::KIND_FADE_OUT:
                  cur_pal[a] = step_out(cur_pal[a], 1'b0);
                pfe_pkg::KIND_FLASH_IN:
                  cur_pal[a] = step_toward(cur_pal[a], tgt_pal[a], 1'b0);
                default:
                  cur_pal[a] = step_out(cur_pal[a], 1'b1);
              endcase
            end
          end
          // The tick that carries the count past the last frame ends it.
          if (frame_cnt + 1 > LAST_FRAME) begin
            frame_cnt = '0;
            fade_on   = 1'b0;
            res.done  = 1'b1;
          end else begin
            frame_cnt = frame_cnt + 5'd1;
          end
        end
      end
      default: ;
    endcase
    res.busy = fade_on;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Item channel: one transaction per call, prediction at the accept edge.
  // On return valid is still high with the old payload; the next call or
  // wait_for_drain replaces or lowers it in the same time step.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [2:0] mode, input logic bank, input logic [5:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [1:0] kind);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    bank_i        <= bank;
    entry_index_i <= idx;
    red_in_i      <= r;
    green_in_i    <= g;
    blue_in_i     <= b;
    fade_kind_i   <= kind;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_palette_item(mode, bank, idx, r, g, b, kind));
    item_count++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block idle. All three are written each
  // time; poke_unused adds a write to the empty index, which must do nothing.
  task automatic write_settings(input logic [5:0] first, input logic [5:0] last,
                                input logic skip, input bit poke_unused);
    logic [1:0] idx_list  [4];
    logic [5:0] data_list [4];
    int         n;
    wait_for_drain();
    idx_list[0]  = pfe_pkg::CFG_FIRST_ENTRY;
    data_list[0] = first;
    idx_list[1]  = pfe_pkg::CFG_LAST_OFFSET;
    data_list[1] = last;
    idx_list[2]  = pfe_pkg::CFG_SKIP_BANK;
    data_list[2] = {5'($urandom_range(0, 31)), skip}; // only bit 0 counts
    idx_list[3]  = CFG_UNUSED;
    data_list[3] = 6'($urandom_range(0, 63));
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_list[k];
      cfg_data_i  <= data_list[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx_list[k])
        pfe_pkg::CFG_FIRST_ENTRY: cfg_first = data_list[k];
        pfe_pkg::CFG_LAST_OFFSET: cfg_last  = data_list[k];
        pfe_pkg::CFG_SKIP_BANK:   cfg_skip  = data_list[k][0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Colour channel biased to the values fades care about: black, full,
  // multiples of the step; the rest fully random.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return pfe_pkg::STEP * 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] pick_setting();
    case ($urandom_range(0, 2))
      0:       return 6'd0;
      1:       return 6'd63;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result channel: random stall bursts, then an in-order check.
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
    out_stall_i <= (stall_left > 0);
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    pal_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result with nothing pending: rgb %0d %0d %0d done %0d busy %0d",
                   red_out_o, green_out_o, blue_out_o, fade_done_o, fade_busy_o);
      end else begin
        want = pending_results.pop_front();
        check_field("red_out", want.red, red_out_o);
        check_field("green_out", want.green, green_out_o);
        check_field("blue_out", want.blue, blue_out_o);
        check_field("fade_done", want.done, fade_done_o);
        check_field("fade_busy", want.busy, fade_busy_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_palette_fade_engine: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Entry writes and reads at the field extremes, a tick with no fade
  // running, and the modes without an operation.
  task automatic test_basic_access();
    write_settings(pfe_pkg::FIRST_RST, pfe_pkg::LAST_RST, 1'b0, 1'b0);
    send_item(pfe_pkg::MODE_WR_TARGET, 1'b0, 6'd0, 8'hFF, 8'hFF, 8'hFF,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_WR_TARGET, 1'b1, 6'd63, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FLASH_OUT);
    send_item(pfe_pkg::MODE_WR_CURRENT, 1'b0, 6'd0, 8'h00, 8'hFF, 8'h00,
              pfe_pkg::KIND_FADE_OUT);
    send_item(pfe_pkg::MODE_WR_CURRENT, 1'b1, 6'd63, 8'hFF, 8'h00, 8'hFF,
              pfe_pkg::KIND_FLASH_IN);
    send_item(pfe_pkg::MODE_RD_CURRENT, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_RD_CURRENT, 1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF,
              pfe_pkg::KIND_FLASH_OUT);
    send_item(pfe_pkg::MODE_RD_CURRENT, 1'b1, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_TICK, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    for (int u = 0; u < 3; u++)
      send_item(MODE_FIRST_UNUSED + 3'(u), 1'($urandom), 6'($urandom), rand_chan(),
                rand_chan(), rand_chan(), 2'($urandom));
  endtask

  // Every fade kind started once, each later one restarting the last, with a
  // tick after each start and a read after every start but the fade-out one.
  task automatic test_fade_kinds();
    send_item(pfe_pkg::MODE_START, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_OUT);
    send_item(pfe_pkg::MODE_TICK, 1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF,
              pfe_pkg::KIND_FADE_OUT);
    send_item(pfe_pkg::MODE_START, 1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF,
              pfe_pkg::KIND_FLASH_OUT);
    send_item(pfe_pkg::MODE_TICK, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_RD_CURRENT, 1'b1, 6'd63, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_START, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FLASH_IN);
    send_item(pfe_pkg::MODE_TICK, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_RD_CURRENT, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_START, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_TICK, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_RD_CURRENT, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
    send_item(pfe_pkg::MODE_TICK, 1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF,
              pfe_pkg::KIND_FLASH_OUT);
    send_item(pfe_pkg::MODE_RD_CURRENT, 1'b1, 6'd63, 8'h00, 8'h00, 8'h00,
              pfe_pkg::KIND_FADE_IN);
  endtask

  // Load entries in a small window, start a fade, tick it to completion
  // (or cut it short so the next phase restarts it), with stray accesses
  // between ticks, then read the window back.
  task automatic run_fade_sequence(input bit cut_short);
    int base;
    int n_ticks;
    base = $urandom_range(0, 63);
    repeat ($urandom_range(4, 12))
      send_item($urandom_range(0, 1) ? pfe_pkg::MODE_WR_TARGET : pfe_pkg::MODE_WR_CURRENT,
                1'($urandom), 6'(base + $urandom_range(0, 7)), rand_chan(), rand_chan(),
                rand_chan(), 2'($urandom));
    send_item(pfe_pkg::MODE_START, 1'($urandom), 6'($urandom), rand_chan(), rand_chan(),
              rand_chan(), 2'($urandom));
    n_ticks = cut_short ? $urandom_range(1, 12) : $urandom_range(LAST_FRAME + 1, LAST_FRAME + 3);
    repeat (n_ticks) begin
      if ($urandom_range(0, 9) == 0)
        send_item(3'($urandom_range(0, 2)), 1'($urandom), 6'(base + $urandom_range(0, 7)),
                  rand_chan(), rand_chan(), rand_chan(), 2'($urandom));
      send_item(pfe_pkg::MODE_TICK, 1'($urandom), 6'($urandom), rand_chan(), rand_chan(),
                rand_chan(), 2'($urandom));
    end
    repeat ($urandom_range(2, 5))
      send_item(pfe_pkg::MODE_RD_CURRENT, 1'($urandom), 6'(base + $urandom_range(0, 7)),
                rand_chan(), rand_chan(), rand_chan(), 2'($urandom));
  endtask

  // Phases under changing register settings: mostly complete fades, some
  // cut short, some pure noise over all mode codes.
  task automatic test_random_fades();
    int start_count;
    int phase;
    int sel;
    start_count = item_count;
    phase       = 0;
    while (item_count - start_count < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - (item_count - start_count) < QUIET_ITEMS) quiet = 1'b1;
      case (phase)
        0:       write_settings(6'd63, 6'd63, 1'b1, 1'b1);
        1:       write_settings(6'd0, 6'd0, 1'b0, 1'b0);
        2:       write_settings(6'd40, 6'd63, 1'b0, 1'b0); // range runs off the end
        3:       write_settings(6'd0, 6'd63, 1'b1, 1'b0);
        default: write_settings(pick_setting(), pick_setting(), 1'($urandom), 1'b0);
      endcase
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        run_fade_sequence(1'b0);
      end else if (sel < 17) begin
        run_fade_sequence(1'b1);
      end else begin
        repeat ($urandom_range(10, 25))
          send_item(3'($urandom), 1'($urandom), 6'($urandom), rand_chan(), rand_chan(),
                    rand_chan(), 2'($urandom));
      end
      phase++;
    end
  endtask

  initial begin
    for (int i = 0; i < 2 * ENTRIES; i++) begin
      cur_pal[i] = '0;
      tgt_pal[i] = '0;
    end
    fade_kind_q = pfe_pkg::KIND_FADE_IN;
    fade_on     = 1'b0;
    frame_cnt   = '0;
    cfg_first   = pfe_pkg::FIRST_RST;
    cfg_last    = pfe_pkg::LAST_RST;
    cfg_skip    = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_access();
    test_fade_kinds();
    test_random_fades();

    // Let the last results drain, then give a full tick's worth of cycles
    // for anything stray to show up.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_palette_fade_engine: PASS");
    end else begin
      $display("tb_palette_fade_engine: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/pfe_pkg.sv
sv/palette_fade_engine.sv
sim/tb_palette_fade_engine.sv
